// File: hdl/radix_integer_to_ascii_unit_macros.svh
`ifndef RADIX_INTEGER_TO_ASCII_UNIT_MACROS_SVH
`define RADIX_INTEGER_TO_ASCII_UNIT_MACROS_SVH

// Clocked check with explicit clock and reset.
`define RITOA_ASSERT_CR(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check on clk_i, held off during rst_ni.
`define RITOA_ASSERT(label, prop, msg) \
  `RITOA_ASSERT_CR(label, clk_i, rst_ni, prop, msg)

`endif

// File: hdl/ritoa_pkg.sv
`timescale 1ns / 1ps

package ritoa_pkg;

  localparam int VALUE_BITS_DEF = 64;
  localparam int MAX_DIGITS_DEF = 64;

  localparam int VALUE_W     = 64;
  localparam int BASE_W      = 6;
  localparam int CHAR_W      = 7;
  localparam int COUNT_W     = 7;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 16;

  localparam logic [BASE_W-1:0] MIN_BASE  = 6'd2;
  localparam logic [BASE_W-1:0] MAX_BASE  = 6'd36;
  localparam logic [BASE_W-1:0] DEC_RADIX = 6'd10;

  localparam logic [CHAR_W-1:0] ASCII_ZERO    = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 7'd65;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [BASE_W-1:0] rem);
    logic [CHAR_W-1:0] r;
    r = {1'b0, rem};
    if (rem < DEC_RADIX) begin
      digit_ascii = ASCII_ZERO + r;
    end else begin
      digit_ascii = ASCII_UPPER_A + r - {1'b0, DEC_RADIX};
    end
  endfunction

endpackage

// File: hdl/ritoa_divider.sv
`timescale 1ns / 1ps
`include "radix_integer_to_ascii_unit_macros.svh"

// restoring divider, one quotient bit per cycle
module ritoa_divider
  import ritoa_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] dividend_i,
  input  logic [BASE_W-1:0]     divisor_i,
  output logic [VALUE_BITS-1:0] quotient_o,
  output logic [BASE_W-1:0]     remainder_o,
  output div_stat_t             stat_o
);

  localparam int SW = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0] quo_q, quo_d;
  logic [BASE_W-1:0]     rem_q, rem_d;
  logic [SW-1:0]         cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;

  logic [BASE_W:0] trial;
  logic [BASE_W:0] diff;
  logic            fits;

  assign trial = {rem_q, quo_q[VALUE_BITS-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign fits  = trial >= {1'b0, divisor_i};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = SW'(VALUE_BITS - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[VALUE_BITS-2:0], fits};
      rem_d = fits ? diff[BASE_W-1:0] : trial[BASE_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

  `RITOA_ASSERT(a_rem_below_div, done_q |-> (rem_q < divisor_i), "remainder not below divisor")
  `RITOA_ASSERT(a_busy_done_excl, !(busy_q && done_q), "divider busy and done together")
  `RITOA_ASSERT(a_done_after_busy, done_q |-> $past(busy_q), "done without a running division")

endmodule

// File: hdl/radix_integer_to_ascii_unit.sv
`timescale 1ns / 1ps
`include "radix_integer_to_ascii_unit_macros.svh"

// channel   dir  fields (tdata / tuser / tlast)
// s_axis    in   tdata: value[63:0], base[69:64]; pad to 72
// m_axis    out  tdata: digit_char[6:0], digit_count[13:7]; tuser: bad_base; tlast: last
//
// One input per conversion, one output transfer per digit (one for a bad base).
// Each digit comes from the bit-serial divider, then emission reads the digits back
// from the digit memory, each through the S_RD and S_EMIT states.
// Input is taken only between conversions; the final digit may sit in the output
// register while the next input is taken. Output stalls hold the sequencer.
// Reset clears control only; the digit memory needs no clearing.
module radix_integer_to_ascii_unit
  import ritoa_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // value[63:0], base[69:64], zero pad
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,   // digit_char[6:0], digit_count[13:7], pad
  output logic                   m_axis_tlast_o,
  output logic                   m_axis_tuser_o    // bad_base
);

  localparam int AW = $clog2(MAX_DIGITS);
  localparam int CW = $clog2(MAX_DIGITS + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_RD   = 5'b00100,
    S_EMIT = 5'b01000,
    S_ERR  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [BASE_W-1:0] base_q, base_d;
  logic [CW-1:0]     n_q, n_d;
  logic [AW-1:0]     rd_addr_q, rd_addr_d;

  logic [BASE_W-1:0] mem [MAX_DIGITS];
  logic [BASE_W-1:0] rd_data_q;
  logic              mem_we;

  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  logic [VALUE_BITS-1:0] div_quot;
  logic [BASE_W-1:0]     div_rem;
  div_stat_t             div_stat;

  logic              out_valid_q, out_valid_d;
  logic [CHAR_W-1:0] out_char_q, out_char_d;
  logic [CW-1:0]     out_count_q, out_count_d;
  logic              out_last_q, out_last_d;
  logic              out_bad_q, out_bad_d;
  logic              out_load;
  logic              out_free;

  logic              in_xfer;
  logic [BASE_W-1:0] in_base;
  logic              in_bad;
  logic [CW-1:0]     n_next;

  assign in_base = s_axis_tdata_i[VALUE_W +: BASE_W];
  assign in_bad  = (in_base < MIN_BASE) || (in_base > MAX_BASE);
  assign in_xfer = s_axis_tvalid_i && s_axis_tready_o;
  assign n_next  = n_q + 1'b1;
  assign out_free = !out_valid_q || m_axis_tready_i;

  assign s_axis_tready_o = (state_q == S_IDLE);

  assign div_dividend = (state_q == S_IDLE) ? s_axis_tdata_i[VALUE_BITS-1:0] : div_quot;

  ritoa_divider #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (base_q),
    .quotient_o (div_quot),
    .remainder_o(div_rem),
    .stat_o     (div_stat)
  );

  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    n_d         = n_q;
    rd_addr_d   = rd_addr_q;
    div_start   = 1'b0;
    mem_we      = 1'b0;
    out_load    = 1'b0;
    out_char_d  = out_char_q;
    out_count_d = out_count_q;
    out_last_d  = out_last_q;
    out_bad_d   = out_bad_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_bad) begin
            state_d = S_ERR;
          end else begin
            base_d    = in_base;
            n_d       = '0;
            div_start = 1'b1;
            state_d   = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          mem_we = 1'b1;
          n_d    = n_next;
          if ((div_quot == '0) || (n_next == CW'(MAX_DIGITS))) begin
            rd_addr_d = n_q[AW-1:0];
            state_d   = S_RD;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      S_RD: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_char_d  = digit_ascii(rd_data_q);
          out_count_d = n_q;
          out_last_d  = (rd_addr_q == '0);
          out_bad_d   = 1'b0;
          if (rd_addr_q == '0) begin
            state_d = S_IDLE;
          end else begin
            rd_addr_d = rd_addr_q - 1'b1;
            state_d   = S_RD;
          end
        end
      end
      S_ERR: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_char_d  = '0;
          out_count_d = '0;
          out_last_d  = 1'b1;
          out_bad_d   = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_q         <= '0;
      rd_addr_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      rd_addr_q   <= rd_addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q      <= base_d;
    out_char_q  <= out_char_d;
    out_count_q <= out_count_d;
    out_last_q  <= out_last_d;
    out_bad_q   <= out_bad_d;
  end

  // digit memory: one write port, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[n_q[AW-1:0]] <= div_rem;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_q];
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA_W - CHAR_W - COUNT_W){1'b0}},
                            COUNT_W'(out_count_q), out_char_q};
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_bad_q;

  `RITOA_ASSERT(a_bad_single, (out_valid_q && out_bad_q) |-> (out_last_q && (out_count_q == '0)), "bad base result malformed")
  `RITOA_ASSERT(a_count_bound, n_q <= CW'(MAX_DIGITS), "digit count beyond store")
  `RITOA_ASSERT(a_start_idle_div, div_start |-> !div_stat.busy, "divider restarted while busy")
  `RITOA_ASSERT(a_digit_count, (out_valid_q && !out_bad_q) |-> (out_count_q != '0), "digit result with zero count")

endmodule
